// ===== src/lpc_pkg.sv =====
package lpc_pkg;

	localparam int DEF_MAX_ORDER = 16;

	// configuration register indexes
	localparam logic [1:0] CFG_ORDER  = 2'd0;
	localparam logic [1:0] CFG_FLOOR  = 2'd1;
	localparam logic [1:0] CFG_FACTOR = 2'd2;

	localparam logic [4:0]  RST_ORDER  = 5'd16;
	localparam logic [30:0] RST_FLOOR  = 31'd1;
	localparam logic [15:0] RST_FACTOR = 16'd65208;

	// 0.999 in Q1.30
	localparam logic [29:0] RMAX = 30'd1072668082;

	typedef struct packed {
		logic signed [31:0] lag_value;
		logic               last_lag;
	} lag_in_t;

	typedef struct packed {
		logic signed [31:0] coef_value;
		logic [3:0]         coef_index;
		logic [30:0]        residual_energy;
		logic               last_coef;
	} coef_out_t;

	typedef struct packed {
		logic [4:0]  order;
		logic [30:0] floor;
		logic [15:0] factor;
	} lpc_cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] res;
		if (x > 64'sd2147483647) begin
			res = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = x[31:0];
		end
		return res;
	endfunction

endpackage

// ===== src/lpc_fifo.sv =====
module lpc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

// ===== src/lpc_front.sv =====
module lpc_front
	import lpc_pkg::*;
#(
	parameter int MAX_ORDER = DEF_MAX_ORDER,
	parameter int LW = $clog2(MAX_ORDER + 1),
	parameter int CW = $clog2(MAX_ORDER + 2)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        lag_valid,
	output logic                        lag_ready,
	input  lag_in_t                     lag,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_data,
	output logic                        job_valid,
	input  logic                        job_ready,
	output logic [MAX_ORDER:0][31:0]    job_lags,
	output logic [CW-1:0]               job_count,
	output lpc_cfg_t                    job_cfg
);

	logic [MAX_ORDER:0][31:0] lags_q, lags_nx;
	logic [CW-1:0]            cnt_q, cnt_nx;
	lpc_cfg_t                 cfg_q;
	logic                     take;

	assign cfg_ready = 1'b1;
	// a frame is only accepted while the queue has room for its job
	assign lag_ready = job_ready;
	assign take      = lag_valid && lag_ready;
	assign job_valid = take && lag.last_lag;
	assign job_lags  = lags_nx;
	assign job_count = cnt_nx;
	assign job_cfg   = cfg_q;

	always_comb begin
		lags_nx = lags_q;
		cnt_nx  = cnt_q;
		if (cnt_q <= CW'(MAX_ORDER)) begin
			lags_nx[cnt_q[LW-1:0]] = lag.lag_value;
			cnt_nx = cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			cfg_q.order  <= RST_ORDER;
			cfg_q.floor  <= RST_FLOOR;
			cfg_q.factor <= RST_FACTOR;
		end else begin
			if (take) cnt_q <= lag.last_lag ? '0 : cnt_nx;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ORDER:  cfg_q.order  <= cfg_data[4:0];
					CFG_FLOOR:  cfg_q.floor  <= cfg_data[30:0];
					CFG_FACTOR: cfg_q.factor <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) lags_q <= lags_nx;
	end

endmodule

// ===== src/lpc_core.sv =====
module lpc_core
	import lpc_pkg::*;
#(
	parameter int MAX_ORDER = DEF_MAX_ORDER,
	parameter int LW = $clog2(MAX_ORDER + 1),
	parameter int CW = $clog2(MAX_ORDER + 2)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	output logic                     job_ready,
	input  logic [MAX_ORDER:0][31:0] job_lags,
	input  logic [CW-1:0]            job_count,
	input  lpc_cfg_t                 job_cfg,
	output logic                     coef_valid,
	input  logic                     coef_ready,
	output coef_out_t                coef
);

	localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_ITER, S_SUM, S_SUM_ACC, S_DCHK, S_DIV, S_REFL,
		S_UPD_A, S_UPD_B, S_UPD_C, S_UPD_D,
		S_ERR_A, S_ERR_B, S_ERR_C, S_ERR_D, S_ERR_E, S_ERR_F,
		S_EXP_A, S_EXP_B, S_EXP_C, S_EXP_D, S_EMIT
	} state_t;

	state_t  state_q;
	logic [LW-1:0] i_q, j_q;
	logic [4:0]    b_q;

	logic [31:0]        lags_q [MAX_ORDER+1];
	logic [CW-1:0]      cnt_q;
	logic [LW-1:0]      ord_q;
	logic [30:0]        floor_q;
	logic [15:0]        factor_q;
	logic signed [31:0] cstore_q [MAX_ORDER];
	logic [47:0]        err_q;
	logic signed [63:0] rr_q;
	logic [47:0]        rem_q;
	logic [29:0]        q_q;
	logic signed [31:0] r_q, t1_q, t2_q;
	logic signed [63:0] pa_q, prod_q;
	logic [29:0]        rsq_q;
	logic [63:0]        hi_q;
	logic [16:0]        g_q;

	logic [LW-1:0]      la;
	logic [31:0]        lag_rd;
	logic [KW-1:0]      ra;
	logic signed [31:0] coef_rd;
	logic signed [32:0] mul_a, mul_b;
	logic               lag0_ok, iter_done, emit_go, emit_last, div_ge;
	logic [LW-1:0]      half, ord_m1;
	logic [63:0]        mag;
	logic [48:0]        rem2;
	logic [29:0]        qc;
	logic signed [31:0] r_nx;
	logic [31:0]        eres;
	logic [5:0]         ord_raw;

	assign job_ready = (state_q == S_IDLE);

	// one shared lag read port
	always_comb begin
		case (state_q)
			S_ITER:  la = i_q + LW'(1);
			S_SUM:   la = i_q - j_q;
			default: la = '0;
		endcase
	end
	assign lag_rd = (CW'(la) < cnt_q) ? lags_q[la] : '0;

	// one shared coefficient read port
	always_comb begin
		case (state_q)
			S_UPD_B: ra = KW'(i_q - LW'(1) - j_q);
			default: ra = KW'(j_q);
		endcase
	end
	assign coef_rd = cstore_q[ra];

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SUM: begin
				mul_a = {coef_rd[31], coef_rd};
				mul_b = {lag_rd[31], lag_rd};
			end
			S_UPD_A, S_UPD_B: begin
				mul_a = {r_q[31], r_q};
				mul_b = {coef_rd[31], coef_rd};
			end
			S_ERR_A: begin
				mul_a = {r_q[31], r_q};
				mul_b = {r_q[31], r_q};
			end
			S_ERR_C: begin
				mul_a = {1'b0, err_q[47:16]};
				mul_b = {3'b0, rsq_q};
			end
			S_ERR_D: begin
				mul_a = {17'b0, err_q[15:0]};
				mul_b = {3'b0, rsq_q};
			end
			S_EXP_A: begin
				mul_a = {16'b0, g_q};
				mul_b = {17'b0, factor_q};
			end
			S_EXP_C: begin
				mul_a = {coef_rd[31], coef_rd};
				mul_b = {16'b0, g_q};
			end
			default: ;
		endcase
	end

	assign lag0_ok   = $signed({lag_rd[31], lag_rd}) > $signed({2'b0, floor_q});
	assign iter_done = (i_q == ord_q) || (err_q == '0) || (err_q < {1'b0, floor_q, 16'b0});
	assign half      = (i_q + LW'(1)) >> 1;
	assign ord_m1    = ord_q - LW'(1);
	assign mag       = rr_q[63] ? 64'(-rr_q) : 64'(rr_q);
	assign rem2      = {rem_q, 1'b0};
	assign div_ge    = rem2 >= {1'b0, err_q};
	assign qc        = (q_q > RMAX) ? RMAX : q_q;
	assign r_nx      = (!rr_q[63] && rr_q != '0) ? -$signed({2'b0, qc}) : $signed({2'b0, qc});
	assign eres      = err_q[47:16];
	assign emit_go   = !coef_valid || coef_ready;
	assign emit_last = (j_q == ord_m1);

	always_comb begin
		ord_raw = {1'b0, job_cfg.order};
		if (ord_raw == 6'd0) ord_raw = 6'd1;
		if (ord_raw > 6'(MAX_ORDER)) ord_raw = 6'(MAX_ORDER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			b_q        <= '0;
			coef_valid <= 1'b0;
		end else begin
			if (coef_valid && coef_ready) coef_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (job_valid) state_q <= S_INIT;
				S_INIT: begin
					i_q <= '0;
					j_q <= '0;
					state_q <= lag0_ok ? S_ITER : S_EMIT;
				end
				S_ITER: begin
					j_q <= '0;
					state_q <= iter_done ? S_EXP_A : S_SUM;
				end
				S_SUM: state_q <= (j_q == i_q) ? S_DCHK : S_SUM_ACC;
				S_SUM_ACC: begin
					j_q <= j_q + LW'(1);
					state_q <= S_SUM;
				end
				S_DCHK: begin
					b_q <= '0;
					state_q <= (mag >= {16'b0, err_q}) ? S_REFL : S_DIV;
				end
				S_DIV: begin
					b_q <= b_q + 5'd1;
					if (b_q == 5'd29) state_q <= S_REFL;
				end
				S_REFL: begin
					j_q <= '0;
					state_q <= S_UPD_A;
				end
				S_UPD_A: state_q <= (j_q == half) ? S_ERR_A : S_UPD_B;
				S_UPD_B: state_q <= S_UPD_C;
				S_UPD_C: state_q <= S_UPD_D;
				S_UPD_D: begin
					j_q <= j_q + LW'(1);
					state_q <= S_UPD_A;
				end
				S_ERR_A: state_q <= S_ERR_B;
				S_ERR_B: state_q <= S_ERR_C;
				S_ERR_C: state_q <= S_ERR_D;
				S_ERR_D: state_q <= S_ERR_E;
				S_ERR_E: state_q <= S_ERR_F;
				S_ERR_F: begin
					i_q <= i_q + LW'(1);
					state_q <= S_ITER;
				end
				S_EXP_A: begin
					if (j_q == ord_q) begin
						j_q <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_EXP_B;
					end
				end
				S_EXP_B: state_q <= S_EXP_C;
				S_EXP_C: state_q <= S_EXP_D;
				S_EXP_D: begin
					j_q <= j_q + LW'(1);
					state_q <= S_EXP_A;
				end
				S_EMIT: begin
					if (emit_go) begin
						coef_valid <= 1'b1;
						j_q <= j_q + LW'(1);
						if (emit_last) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a * mul_b);
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					for (int k = 0; k <= MAX_ORDER; k++) lags_q[k] <= job_lags[k];
					cnt_q    <= job_count;
					ord_q    <= LW'(ord_raw);
					floor_q  <= job_cfg.floor;
					factor_q <= job_cfg.factor;
				end
			end
			S_INIT: begin
				for (int k = 0; k < MAX_ORDER; k++) cstore_q[k] <= '0;
				err_q <= lag0_ok ? {lag_rd, 16'b0} : '0;
			end
			S_ITER: begin
				rr_q <= {{16{lag_rd[31]}}, lag_rd, 16'b0};
				g_q  <= 17'h10000;
			end
			S_SUM_ACC: rr_q <= rr_q + (prod_q >>> 11);
			S_DCHK: begin
				q_q   <= (mag >= {16'b0, err_q}) ? RMAX : '0;
				rem_q <= mag[47:0];
			end
			S_DIV: begin
				q_q   <= {q_q[28:0], div_ge};
				rem_q <= div_ge ? 48'(rem2 - {1'b0, err_q}) : rem2[47:0];
			end
			S_REFL: begin
				r_q <= r_nx;
				cstore_q[KW'(i_q)] <= r_nx >>> 3;
			end
			S_UPD_A: t1_q <= coef_rd;
			S_UPD_B: begin
				pa_q <= prod_q;
				t2_q <= coef_rd;
			end
			S_UPD_C: cstore_q[KW'(j_q)] <=
				sat32($signed({{32{t1_q[31]}}, t1_q}) + (prod_q >>> 30));
			S_UPD_D: cstore_q[KW'(i_q - LW'(1) - j_q)] <=
				sat32($signed({{32{t2_q[31]}}, t2_q}) + (pa_q >>> 30));
			S_ERR_B: rsq_q <= prod_q[59:30];
			S_ERR_D: hi_q <= prod_q;
			S_ERR_E: hi_q <= hi_q + {16'b0, prod_q[63:16]};
			S_ERR_F: err_q <= err_q - hi_q[61:14];
			S_EXP_B: g_q <= prod_q[32:16];
			S_EXP_D: cstore_q[KW'(j_q)] <= prod_q[47:16];
			S_EMIT: begin
				if (emit_go) begin
					coef.coef_value      <= coef_rd;
					coef.coef_index      <= 4'(j_q);
					coef.residual_energy <= eres[31] ? 31'h7fffffff : eres[30:0];
					coef.last_coef       <= emit_last;
				end
			end
			default: ;
		endcase
	end

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < err_q)
		else $error("divider remainder not below divisor");

	a_refl_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD_A |-> (r_q <= $signed({2'b0, RMAX}) && r_q >= -$signed({2'b0, RMAX})))
		else $error("reflection coefficient out of range");

	a_err_down: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ERR_F |=> err_q <= $past(err_q))
		else $error("error energy grew");

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> j_q < ord_q)
		else $error("emit index past order");

endmodule

// ===== src/levinson_durbin_lpc.sv =====
// Levinson-Durbin LPC solver.
// Lag channel (lag_valid/lag_ready/lag): autocorrelation lags, lag 0 first,
// one item per cycle when ready. The item with last_lag set closes the set and
// queues a job; lags past MAX_ORDER+1 are dropped, missing ones count as zero.
// Coefficient channel (coef_valid/coef_ready/coef): order items per job, tap 0
// first, each carrying the residual energy; last_coef marks the final tap.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no job is pending.
// A two-entry job queue sits between the lag loader and the solver, so a
// new lag set loads while the previous one is solved.
// The solver shares one 33x33 multiplier and a one-bit-per-cycle divider.
// Each recursion step i forms the dot product, divides, then updates the
// coefficients and error energy; expansion and output go tap by tap.
// A stalled coefficient receiver holds the solver in its output phase; the
// lag side keeps loading until the queue is full.
// Reset restores the register defaults (order 16, floor 1, factor 0.995)
// and drops any partial lag set and queued jobs.
module levinson_durbin_lpc
	import lpc_pkg::*;
#(
	parameter int MAX_ORDER = DEF_MAX_ORDER
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        lag_valid,
	output logic        lag_ready,
	input  lag_in_t     lag,
	output logic        coef_valid,
	input  logic        coef_ready,
	output coef_out_t   coef,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW = $clog2(MAX_ORDER + 2);
	localparam int JW = (MAX_ORDER + 1) * 32 + CW + $bits(lpc_cfg_t);

	logic                     push_valid, push_ready, pop_valid, pop_ready;
	logic [MAX_ORDER:0][31:0] f_lags, b_lags;
	logic [CW-1:0]            f_count, b_count;
	lpc_cfg_t                 f_cfg, b_cfg;
	logic [JW-1:0]            pop_data;

	lpc_front #(.MAX_ORDER(MAX_ORDER)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.lag_valid (lag_valid),
		.lag_ready (lag_ready),
		.lag       (lag),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job_lags  (f_lags),
		.job_count (f_count),
		.job_cfg   (f_cfg)
	);

	lpc_fifo #(.WIDTH(JW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({f_lags, f_count, f_cfg}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign {b_lags, b_count, b_cfg} = pop_data;

	lpc_core #(.MAX_ORDER(MAX_ORDER)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (pop_valid),
		.job_ready  (pop_ready),
		.job_lags   (b_lags),
		.job_count  (b_count),
		.job_cfg    (b_cfg),
		.coef_valid (coef_valid),
		.coef_ready (coef_ready),
		.coef       (coef)
	);

endmodule
